@@ src/jmsa_pkg.sv @@
// Shared types and constants for the joystick menu setting adjuster.
package jmsa_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int NULL_W     = 12;
	localparam int DEAD_W     = 11;
	localparam int COUNT_W    = 8;
	localparam int SETTING_W  = 8;
	localparam int MODE_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// divider datapath: dividend up to 7 * 4095, divisor shifted left by up to 8
	localparam int DIV_W      = 16;
	localparam int STEP_W     = 4;
	localparam logic [STEP_W-1:0] SET_STEPS = 4'd4;
	localparam logic [STEP_W-1:0] MOD_STEPS = 4'd9;

	localparam logic [SETTING_W-1:0] SETTING_MAX = 8'd255;
	localparam logic [2:0]           DELTA_MAX   = 3'd7;

	localparam logic [MODE_W-1:0] MODE_BRIGHTNESS = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SPEED      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INTENSITY  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_EFFECT     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PALETTE    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_NULL_POINT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EFFECT_COUNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_WB,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_SUB,
		OP_ADD,
		OP_UP
	} op_t;

endpackage

@@ src/jmsa_if.sv @@
// Valid/ready channel interfaces for samples and results.
interface jmsa_sample_if;
	import jmsa_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] stick_x;
	logic                button_down;

	modport source (output valid, output stick_x, output button_down, input ready);
	modport sink   (input valid, input stick_x, input button_down, output ready);
endinterface

interface jmsa_result_if;
	import jmsa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    menu_mode;
	logic [SETTING_W-1:0] brightness;
	logic [SETTING_W-1:0] effect_speed;
	logic [SETTING_W-1:0] effect_intensity;
	logic [SETTING_W-1:0] effect_index;
	logic [SETTING_W-1:0] palette_index;

	modport source (output valid, output menu_mode, output brightness, output effect_speed,
		output effect_intensity, output effect_index, output palette_index, input ready);
	modport sink (input valid, input menu_mode, input brightness, input effect_speed,
		input effect_intensity, input effect_index, input palette_index, output ready);
endinterface

@@ src/joystick_menu_setting_adjuster_unit.sv @@
// After accept: ST_CALC, then ST_DIV when the delta divides or an index steps up, then ST_WB and
// ST_DONE, which loads the output register once it is free. The shared restoring divider
// retires one quotient bit per cycle (4 bits for the delta map, 9 for the index modulo).
// A finished result waits in the output register while the next sample is accepted.
// Reset (arst_n low, asynchronous): mode 0, both arms set, all settings and indexes 0,
// configuration back to null point 2048, dead zone 200, 16 effects, 8 palettes.
module joystick_menu_setting_adjuster_unit #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [jmsa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jmsa_pkg::CFG_DATA_W-1:0]   cfg_data,
	jmsa_sample_if.sink                       sample,
	jmsa_result_if.source                     result
);
	import jmsa_pkg::*;

	localparam int XW = SAMPLE_W + 1;
	localparam int CW = (SAMPLE_BITS + 1 > XW) ? SAMPLE_BITS + 1 : XW;
	localparam logic [SAMPLE_W-1:0] X_MASK = SAMPLE_W'((17'(1) << SAMPLE_BITS) - 17'(1));
	localparam logic [CW-1:0] FULL = CW'(1) << SAMPLE_BITS;

	state_t state_q, state_nxt;
	op_t    op_q;

	logic [NULL_W-1:0]  null_point_q;
	logic [DEAD_W-1:0]  dead_zone_q;
	logic [COUNT_W-1:0] effect_count_q;
	logic [COUNT_W-1:0] palette_count_q;

	logic [MODE_W-1:0]    mode_q;
	logic                 button_armed_q;
	logic                 stick_armed_q;
	logic [SETTING_W-1:0] brightness_q, speed_q, intensity_q, effect_q, palette_q;

	logic [SAMPLE_W-1:0] x_q;
	logic [DIV_W-1:0]    rem_q, dsh_q;
	logic [3:0]          quo_q;
	logic [STEP_W-1:0]   step_q;

	logic                 out_valid_q;
	logic [MODE_W-1:0]    out_mode_q;
	logic [SETTING_W-1:0] out_bright_q, out_speed_q, out_inten_q, out_effect_q, out_palette_q;

	logic sample_acc, out_load;

	// sample window math
	logic [XW-1:0]         xe, hi;
	logic signed [XW-1:0]  lo;
	logic                  right, left, band, lo_pos;
	logic [SAMPLE_W-1:0]   dev_right;
	logic [SAMPLE_W-1:0]   num_base;
	logic [DIV_W-1:0]      num7;
	logic [CW-1:0]         x_plus_d;
	logic                  at_top, at_bottom;
	logic [SETTING_W-1:0]  sel_setting, sel_idx, sel_cnt;
	logic [SETTING_W:0]    idx_inc;

	// divider step and writeback
	logic                  div_ge;
	logic [2:0]            delta;
	logic [SETTING_W:0]    add_sum;
	logic [SETTING_W-1:0]  upd_val;

	assign xe        = {1'b0, x_q};
	assign hi        = {1'b0, null_point_q} + {2'b00, dead_zone_q};
	assign lo        = $signed({1'b0, null_point_q}) - $signed({2'b00, dead_zone_q});
	assign right     = xe > hi;
	assign left      = $signed(xe) < lo;
	assign band      = ($signed(xe) > lo) && (xe < hi);
	assign lo_pos    = !lo[XW-1] && (lo != '0);
	assign dev_right = SAMPLE_W'(xe - hi);
	assign num_base  = right ? dev_right : x_q;
	assign num7      = DIV_W'({num_base, 3'b000}) - DIV_W'(num_base);

	assign x_plus_d  = CW'(x_q) + CW'(dead_zone_q);
	assign at_top    = x_plus_d > FULL;
	assign at_bottom = {1'b0, x_q} < {2'b00, dead_zone_q};

	always_comb begin
		case (mode_q)
			MODE_BRIGHTNESS: sel_setting = brightness_q;
			MODE_SPEED:      sel_setting = speed_q;
			default:         sel_setting = intensity_q;
		endcase
	end

	assign sel_idx = (mode_q == MODE_EFFECT) ? effect_q : palette_q;
	always_comb begin
		sel_cnt = (mode_q == MODE_EFFECT) ? effect_count_q : palette_count_q;
		if (sel_cnt == '0) begin
			sel_cnt = 8'd1;
		end
	end
	assign idx_inc = {1'b0, sel_idx} + 9'd1;

	assign div_ge  = rem_q >= dsh_q;
	assign delta   = (op_q == OP_SUB) ? (quo_q[3] ? DELTA_MAX : quo_q[2:0]) : DELTA_MAX - quo_q[2:0];
	assign add_sum = {1'b0, sel_setting} + {6'b0, delta};

	always_comb begin
		case (op_q)
			OP_SUB:  upd_val = (sel_setting < {5'b0, delta}) ? '0 : sel_setting - {5'b0, delta};
			OP_ADD:  upd_val = add_sum[SETTING_W] ? SETTING_MAX : add_sum[SETTING_W-1:0];
			OP_UP:   upd_val = rem_q[SETTING_W-1:0];
			default: upd_val = sel_setting;
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_nxt = ST_CALC;
			end
			ST_CALC: begin
				state_nxt = ST_WB;
				if ((mode_q == MODE_BRIGHTNESS || mode_q == MODE_SPEED ||
				     mode_q == MODE_INTENSITY) && ((right && lo_pos) || (!right && left))) begin
					state_nxt = ST_DIV;
				end else if ((mode_q == MODE_EFFECT || mode_q == MODE_PALETTE) &&
				             stick_armed_q && !at_top && at_bottom) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (step_q == STEP_W'(1)) state_nxt = ST_WB;
			end
			ST_WB: state_nxt = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || result.ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		sample_acc = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: sample_acc = sample.valid;
			ST_DONE: out_load   = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	assign sample.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			null_point_q    <= 12'd2048;
			dead_zone_q     <= 11'd200;
			effect_count_q  <= 8'd16;
			palette_count_q <= 8'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NULL_POINT:    null_point_q    <= cfg_data[NULL_W-1:0];
				CFG_DEAD_ZONE:     dead_zone_q     <= cfg_data[DEAD_W-1:0];
				CFG_EFFECT_COUNT:  effect_count_q  <= cfg_data[COUNT_W-1:0];
				CFG_PALETTE_COUNT: palette_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_BRIGHTNESS;
			button_armed_q <= 1'b1;
			stick_armed_q  <= 1'b1;
			brightness_q   <= '0;
			speed_q        <= '0;
			intensity_q    <= '0;
			effect_q       <= '0;
			palette_q      <= '0;
		end else begin
			if (sample_acc) begin
				if (sample.button_down && button_armed_q) begin
					mode_q         <= (mode_q >= MODE_PALETTE) ? MODE_BRIGHTNESS : mode_q + 3'd1;
					button_armed_q <= 1'b0;
				end else if (!sample.button_down) begin
					button_armed_q <= 1'b1;
				end
			end
			if (state_q == ST_CALC) begin
				case (mode_q)
					MODE_BRIGHTNESS, MODE_SPEED, MODE_INTENSITY: begin
						if (right || left) begin
							stick_armed_q <= 1'b0;
						end else if (band) begin
							stick_armed_q <= 1'b1;
						end
					end
					MODE_EFFECT, MODE_PALETTE: begin
						if (at_top && stick_armed_q) begin
							// step down, wrapping from 0 to the count minus one; an index above the count is not wrapped
							if (mode_q == MODE_EFFECT) begin
								effect_q <= (sel_idx == '0) ? sel_cnt - 8'd1 : sel_idx - 8'd1;
							end else begin
								palette_q <= (sel_idx == '0) ? sel_cnt - 8'd1 : sel_idx - 8'd1;
							end
							stick_armed_q <= 1'b0;
						end else if (at_bottom && stick_armed_q) begin
							stick_armed_q <= 1'b0;
						end else if (band) begin
							stick_armed_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_WB && op_q != OP_HOLD) begin
				case (mode_q)
					MODE_BRIGHTNESS: brightness_q <= upd_val;
					MODE_SPEED:      speed_q      <= upd_val;
					MODE_INTENSITY:  intensity_q  <= upd_val;
					MODE_EFFECT:     effect_q     <= upd_val;
					MODE_PALETTE:    palette_q    <= upd_val;
					default: ;
				endcase
			end
		end
	end

	// working registers: sample, op and the restoring divider
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			x_q <= sample.stick_x & X_MASK;
		end
		if (state_q == ST_CALC) begin
			case (mode_q)
				MODE_BRIGHTNESS, MODE_SPEED, MODE_INTENSITY: begin
					if (right) begin
						op_q <= OP_SUB;
					end else if (left) begin
						op_q <= OP_ADD;
					end else begin
						op_q <= OP_HOLD;
					end
					// force a full delta when the lower band edge is not positive
					quo_q  <= (right && !lo_pos) ? 4'b1000 : 4'b0000;
					rem_q  <= num7;
					dsh_q  <= DIV_W'({lo[SAMPLE_W-1:0], 3'b000});
					step_q <= SET_STEPS;
				end
				MODE_EFFECT, MODE_PALETTE: begin
					op_q   <= (stick_armed_q && !at_top && at_bottom) ? OP_UP : OP_HOLD;
					quo_q  <= '0;
					rem_q  <= DIV_W'(idx_inc);
					dsh_q  <= DIV_W'({sel_cnt, 8'b0});
					step_q <= MOD_STEPS;
				end
				default: begin
					op_q  <= OP_HOLD;
					quo_q <= '0;
				end
			endcase
		end
		if (state_q == ST_DIV) begin
			if (div_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q  <= {quo_q[2:0], div_ge};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - STEP_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mode_q    <= mode_q;
			out_bright_q  <= brightness_q;
			out_speed_q   <= speed_q;
			out_inten_q   <= intensity_q;
			out_effect_q  <= effect_q;
			out_palette_q <= palette_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.menu_mode        = out_mode_q;
	assign result.brightness       = out_bright_q;
	assign result.effect_speed     = out_speed_q;
	assign result.effect_intensity = out_inten_q;
	assign result.effect_index     = out_effect_q;
	assign result.palette_index    = out_palette_q;

endmodule
